>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition that must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond) \
	`CHK_ASSERT(lbl, clk, rst_n, !(cond))

`endif

>>> rtl/pfs_pkg.sv
`timescale 1ns / 1ps
package pfs_pkg;

	localparam int QUEUE_DEPTH_C    = 32;
	localparam int SUPPRESS_DEPTH_C = 32;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_TICK    = 2'd1,
		OP_FINISH  = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_QUEUED     = 3'd0,
		ST_SUPPRESSED = 3'd1,
		ST_DROPPED    = 3'd2,
		ST_DISPATCHED = 3'd3,
		ST_NONE       = 3'd4,
		ST_MATCHED    = 3'd5,
		ST_IGNORED    = 3'd6,
		ST_CLEARED    = 3'd7
	} status_t;

	localparam logic [1:0] KIND_AUDIO  = 2'd0;
	localparam logic [1:0] KIND_HAPTIC = 2'd1;
	localparam logic [1:0] KIND_BOTH   = 2'd2;
	localparam logic [1:0] KIND_OTHER  = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] message_tag;
		logic        has_text;
		logic [1:0]  msg_kind;
		logic [2:0]  priority_req;
		logic [1:0]  verb_req;
		logic [31:0] dup_key;
		logic [15:0] cooldown_ms;
		logic        interrupt_flag;
		logic [15:0] elapsed_ms;
		logic [15:0] finished_id;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] dispatched_tag;
		logic [2:0]  dispatched_priority;
		logic        audio_start;
		logic        haptic_fire;
		logic        speech_preempted;
		logic        tts_busy;
		logic [5:0]  queue_count;
	} result_t;

	typedef struct packed {
		logic [15:0] tag;
		logic        text;
		logic [1:0]  kind;
		logic [2:0]  prio;
		logic [1:0]  verb;
	} entry_t;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] remain;
	} supp_t;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_NEXT,
		CMD_SUPPRESS,
		CMD_PURGE_INIT,
		CMD_PURGE_EV,
		CMD_PURGE_END,
		CMD_INSERT,
		CMD_CD_KEEP,
		CMD_CD_DROP_LAST,
		CMD_CD_FETCH_LAST,
		CMD_CD_MOVE,
		CMD_DISP_INIT,
		CMD_DISP_EV,
		CMD_IDLE_TICK,
		CMD_DISPATCH,
		CMD_Q_MOVE,
		CMD_FINISH,
		CMD_CLEAR
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    key_zero;
		logic    intr;
		logic    s_end;
		logic    s_last;
		logic    key_hit;
		logic    expired;
		logic    q_end;
		logic    found;
		logic    need_move;
		logic    idle_skip;
	} ctrl_status_t;

endpackage

>>> rtl/pfs_ram.sv
`timescale 1ns / 1ps
module pfs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/pfs_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  result_strobe,
	input  pfs_pkg::ctrl_status_t stat,
	output pfs_pkg::cmd_t         cmd
);
	import pfs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_KEY_RD,
		S_KEY_EV,
		S_PUR_RD,
		S_PUR_EV,
		S_INS,
		S_CD_RD,
		S_CD_EV,
		S_CD_MV,
		S_DSP_RD,
		S_DSP_EV,
		S_DSP_MV
	} state_t;

	state_t state_q, state_nxt;
	logic   fin;

	assign busy = (state_q != S_IDLE);

	// Sequencing of each operation; fin marks the last step of an item.
	always_comb begin
		state_nxt = state_q;
		cmd       = CMD_NOP;
		fin       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd       = CMD_LOAD;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_ENQUEUE: state_nxt = S_KEY_RD;
					OP_TICK:    state_nxt = S_CD_RD;
					OP_FINISH: begin
						cmd = CMD_FINISH;
						fin = 1'b1;
					end
					OP_CLEAR: begin
						cmd = CMD_CLEAR;
						fin = 1'b1;
					end
					default: fin = 1'b1;
				endcase
			end
			S_KEY_RD: begin
				if (stat.key_zero || stat.s_end) begin
					if (stat.intr) begin
						cmd       = CMD_PURGE_INIT;
						state_nxt = S_PUR_RD;
					end else begin
						cmd = CMD_INSERT;
						fin = 1'b1;
					end
				end else begin
					state_nxt = S_KEY_EV;
				end
			end
			S_KEY_EV: begin
				if (stat.key_hit) begin
					cmd = CMD_SUPPRESS;
					fin = 1'b1;
				end else begin
					cmd       = CMD_NEXT;
					state_nxt = S_KEY_RD;
				end
			end
			S_PUR_RD: begin
				if (stat.q_end) begin
					cmd       = CMD_PURGE_END;
					state_nxt = S_INS;
				end else begin
					state_nxt = S_PUR_EV;
				end
			end
			S_PUR_EV: begin
				cmd       = CMD_PURGE_EV;
				state_nxt = S_PUR_RD;
			end
			S_INS: begin
				cmd = CMD_INSERT;
				fin = 1'b1;
			end
			S_CD_RD: begin
				if (stat.s_end) begin
					if (stat.idle_skip) begin
						cmd = CMD_IDLE_TICK;
						fin = 1'b1;
					end else begin
						cmd       = CMD_DISP_INIT;
						state_nxt = S_DSP_RD;
					end
				end else begin
					state_nxt = S_CD_EV;
				end
			end
			S_CD_EV: begin
				state_nxt = S_CD_RD;
				if (!stat.expired) begin
					cmd = CMD_CD_KEEP;
				end else if (stat.s_last) begin
					cmd = CMD_CD_DROP_LAST;
				end else begin
					cmd       = CMD_CD_FETCH_LAST;
					state_nxt = S_CD_MV;
				end
			end
			S_CD_MV: begin
				cmd       = CMD_CD_MOVE;
				state_nxt = S_CD_RD;
			end
			S_DSP_RD: begin
				if (stat.q_end) begin
					if (!stat.found) begin
						cmd = CMD_IDLE_TICK;
						fin = 1'b1;
					end else begin
						cmd = CMD_DISPATCH;
						if (stat.need_move) begin
							state_nxt = S_DSP_MV;
						end else begin
							fin = 1'b1;
						end
					end
				end else begin
					state_nxt = S_DSP_EV;
				end
			end
			S_DSP_EV: begin
				cmd       = CMD_DISP_EV;
				state_nxt = S_DSP_RD;
			end
			S_DSP_MV: begin
				cmd = CMD_Q_MOVE;
				fin = 1'b1;
			end
			default: state_nxt = S_IDLE;
		endcase
		if (fin) begin
			state_nxt = S_IDLE;
		end
	end

	// State and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			result_strobe <= 1'b0;
		end else begin
			state_q       <= state_nxt;
			result_strobe <= fin;
		end
	end

	`CHK_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	`CHK_ASSERT(a_strobe_idle, clk, arst_n, result_strobe |-> !busy)
	`CHK_ASSERT(a_strobe_single, clk, arst_n, result_strobe |=> !result_strobe)
endmodule

>>> rtl/pfs_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfs_datapath #(
	parameter int QDEPTH = pfs_pkg::QUEUE_DEPTH_C,
	parameter int SDEPTH = pfs_pkg::SUPPRESS_DEPTH_C
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfs_pkg::cmd_t         cmd,
	input  pfs_pkg::item_t        item,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata,
	output pfs_pkg::ctrl_status_t stat,
	output pfs_pkg::result_t      result
);
	import pfs_pkg::*;

	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);
	localparam int SAW = $clog2(SDEPTH);
	localparam int SCW = $clog2(SDEPTH + 1);
	localparam int IW  = (QCW > SCW) ? QCW : SCW;

	logic [QCW-1:0] qfill_q;
	logic [SCW-1:0] sfill_q;
	logic [IW-1:0]  idx_q;
	logic [QCW-1:0] wr_q;
	logic [QAW-1:0] best_q;
	logic           found_q;
	logic           pre_q;
	logic           busy_q;
	logic [15:0]    sid_q;
	logic [2:0]     sprio_q;
	logic [1:0]     thr_q;
	item_t          item_q;
	entry_t         best_e_q;
	result_t        res_q;

	entry_t         q_rd, q_wdata, new_e;
	supp_t          s_rd, s_wdata;
	logic           q_we, s_we;
	logic [QAW-1:0] q_raddr, q_waddr, q_last;
	logic [SAW-1:0] s_raddr, s_waddr, s_last_addr;
	logic           q_full, s_full, elig, audio, haptic, fin_match;

	assign q_last      = QAW'(qfill_q - QCW'(1));
	assign s_last_addr = SAW'(sfill_q - SCW'(1));
	assign q_full      = (qfill_q >= QCW'(QDEPTH));
	assign s_full      = (sfill_q >= SCW'(SDEPTH));

	assign new_e = '{tag: item_q.message_tag, text: item_q.has_text, kind: item_q.msg_kind,
		prio: item_q.priority_req, verb: item_q.verb_req};

	// Candidate test for the dispatch scan: earliest entry of highest priority wins.
	assign elig = (q_rd.verb <= thr_q) && (!found_q || (q_rd.prio > best_e_q.prio));

	assign audio  = ((best_e_q.kind == KIND_AUDIO) || (best_e_q.kind == KIND_BOTH))
		&& best_e_q.text;
	assign haptic = (best_e_q.kind == KIND_HAPTIC) || (best_e_q.kind == KIND_BOTH);
	assign fin_match = busy_q && (sid_q == item_q.finished_id);

	// Memory addressing and write control.
	always_comb begin
		q_raddr = (cmd == CMD_DISPATCH) ? q_last : idx_q[QAW-1:0];
		s_raddr = (cmd == CMD_CD_FETCH_LAST) ? s_last_addr : idx_q[SAW-1:0];
		q_we    = 1'b0;
		q_waddr = wr_q[QAW-1:0];
		q_wdata = q_rd;
		s_we    = 1'b0;
		s_waddr = idx_q[SAW-1:0];
		s_wdata = s_rd;
		unique case (cmd)
			CMD_PURGE_EV: q_we = (q_rd.prio >= item_q.priority_req);
			CMD_INSERT: begin
				q_we    = !q_full;
				q_waddr = qfill_q[QAW-1:0];
				q_wdata = new_e;
				s_we    = !q_full && (item_q.dup_key != 32'd0) && !s_full;
				s_waddr = sfill_q[SAW-1:0];
				s_wdata = '{key: item_q.dup_key, remain: item_q.cooldown_ms};
			end
			CMD_Q_MOVE: begin
				q_we    = 1'b1;
				q_waddr = best_q;
			end
			CMD_CD_KEEP: begin
				s_we    = 1'b1;
				s_wdata = '{key: s_rd.key, remain: s_rd.remain - item_q.elapsed_ms};
			end
			CMD_CD_MOVE: s_we = 1'b1;
			default: begin
			end
		endcase
	end

	pfs_ram #(.WIDTH($bits(entry_t)), .DEPTH(QDEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rd)
	);

	pfs_ram #(.WIDTH($bits(supp_t)), .DEPTH(SDEPTH)) u_supp_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rd)
	);

	// Status towards the controller.
	always_comb begin
		stat.op        = opcode_t'(item_q.opcode);
		stat.key_zero  = (item_q.dup_key == 32'd0);
		stat.intr      = item_q.interrupt_flag;
		stat.s_end     = (idx_q >= IW'(sfill_q));
		stat.s_last    = (idx_q == IW'(s_last_addr));
		stat.key_hit   = (s_rd.key == item_q.dup_key);
		stat.expired   = (s_rd.remain <= item_q.elapsed_ms);
		stat.q_end     = (idx_q >= IW'(qfill_q));
		stat.found     = found_q;
		stat.need_move = (best_q != q_last);
		stat.idle_skip = busy_q || (qfill_q == '0);
	end

	assign result = res_q;

	// Control state: fill counts, scan indices and speech state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qfill_q <= '0;
			sfill_q <= '0;
			idx_q   <= '0;
			wr_q    <= '0;
			best_q  <= '0;
			found_q <= 1'b0;
			pre_q   <= 1'b0;
			busy_q  <= 1'b0;
			sid_q   <= '0;
			sprio_q <= '0;
			thr_q   <= 2'd1;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			unique case (cmd)
				CMD_LOAD: begin
					idx_q   <= '0;
					wr_q    <= '0;
					found_q <= 1'b0;
					pre_q   <= 1'b0;
				end
				CMD_NEXT, CMD_CD_KEEP: idx_q <= idx_q + IW'(1);
				CMD_PURGE_INIT: begin
					idx_q <= '0;
					wr_q  <= '0;
					if (busy_q && (item_q.priority_req > sprio_q)) begin
						busy_q  <= 1'b0;
						sid_q   <= '0;
						sprio_q <= '0;
						pre_q   <= 1'b1;
					end
				end
				CMD_PURGE_EV: begin
					idx_q <= idx_q + IW'(1);
					if (q_rd.prio >= item_q.priority_req) begin
						wr_q <= wr_q + QCW'(1);
					end
				end
				CMD_PURGE_END: qfill_q <= wr_q;
				CMD_INSERT: begin
					if (!q_full) begin
						qfill_q <= qfill_q + QCW'(1);
						if ((item_q.dup_key != 32'd0) && !s_full) begin
							sfill_q <= sfill_q + SCW'(1);
						end
					end
				end
				CMD_CD_DROP_LAST, CMD_CD_MOVE: sfill_q <= sfill_q - SCW'(1);
				CMD_DISP_INIT: begin
					idx_q   <= '0;
					found_q <= 1'b0;
				end
				CMD_DISP_EV: begin
					idx_q <= idx_q + IW'(1);
					if (elig) begin
						best_q  <= idx_q[QAW-1:0];
						found_q <= 1'b1;
					end
				end
				CMD_DISPATCH: begin
					qfill_q <= qfill_q - QCW'(1);
					if (audio) begin
						busy_q  <= 1'b1;
						sid_q   <= best_e_q.tag;
						sprio_q <= best_e_q.prio;
					end
				end
				CMD_FINISH: begin
					if (fin_match) begin
						busy_q  <= 1'b0;
						sid_q   <= '0;
						sprio_q <= '0;
					end
				end
				CMD_CLEAR: begin
					qfill_q <= '0;
					sfill_q <= '0;
					busy_q  <= 1'b0;
					sid_q   <= '0;
					sprio_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload: latched item, best candidate and the result of the step.
	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			item_q <= item;
		end
		if ((cmd == CMD_DISP_EV) && elig) begin
			best_e_q <= q_rd;
		end
		unique case (cmd)
			CMD_SUPPRESS: res_q <= '{status: ST_SUPPRESSED, dispatched_tag: '0,
				dispatched_priority: '0, audio_start: 1'b0, haptic_fire: 1'b0,
				speech_preempted: 1'b0, tts_busy: busy_q, queue_count: 6'(qfill_q)};
			CMD_INSERT: res_q <= '{status: q_full ? ST_DROPPED : ST_QUEUED,
				dispatched_tag: '0, dispatched_priority: '0, audio_start: 1'b0,
				haptic_fire: 1'b0, speech_preempted: pre_q, tts_busy: busy_q,
				queue_count: q_full ? 6'(qfill_q) : 6'(qfill_q + QCW'(1))};
			CMD_IDLE_TICK: res_q <= '{status: ST_NONE, dispatched_tag: '0,
				dispatched_priority: '0, audio_start: 1'b0, haptic_fire: 1'b0,
				speech_preempted: 1'b0, tts_busy: busy_q, queue_count: 6'(qfill_q)};
			CMD_DISPATCH: res_q <= '{status: ST_DISPATCHED, dispatched_tag: best_e_q.tag,
				dispatched_priority: best_e_q.prio, audio_start: audio,
				haptic_fire: haptic, speech_preempted: 1'b0, tts_busy: audio,
				queue_count: 6'(qfill_q - QCW'(1))};
			CMD_FINISH: res_q <= '{status: fin_match ? ST_MATCHED : ST_IGNORED,
				dispatched_tag: '0, dispatched_priority: '0, audio_start: 1'b0,
				haptic_fire: 1'b0, speech_preempted: 1'b0,
				tts_busy: busy_q && !fin_match, queue_count: 6'(qfill_q)};
			CMD_CLEAR: res_q <= '{status: ST_CLEARED, dispatched_tag: '0,
				dispatched_priority: '0, audio_start: 1'b0, haptic_fire: 1'b0,
				speech_preempted: 1'b0, tts_busy: 1'b0, queue_count: 6'd0};
			default: begin
			end
		endcase
	end

	`CHK_ASSERT(a_qfill_range, clk, arst_n, qfill_q <= QCW'(QDEPTH))
	`CHK_ASSERT(a_sfill_range, clk, arst_n, sfill_q <= SCW'(SDEPTH))
	`CHK_NEVER(a_idle_speech_id, clk, arst_n, !busy_q && (sid_q != 16'd0))
endmodule

>>> rtl/priority_feedback_scheduler_core.sv
`timescale 1ns / 1ps
// Priority feedback scheduler. Pulse start with an item while busy is low; exactly
// one result follows, shown for a single cycle with result_strobe high, and the
// receiver cannot stall it, so it must be captured in that cycle. A new item may be
// started in the same cycle that the previous result is strobed. Each operation is
// run by a controller walking the queue and suppression memories entry by entry,
// with a read state and an evaluate state for each entry. An enqueue scans the
// suppression entries and, when it interrupts, also purges the queue; a tick ages
// the suppression entries, refilling the slot of each expired one from the last
// slot, then scans the queue for dispatch unless speech is busy or the queue is
// empty, and refills the dispatched entry's slot from the last slot. No clearing
// pass is needed after reset. verbosity_threshold is written through
// cfg_we/cfg_wdata; the user must write it only while idle, as the block itself
// does not enforce this.
module priority_feedback_scheduler_core #(
	parameter int QUEUE_DEPTH    = pfs_pkg::QUEUE_DEPTH_C,
	parameter int SUPPRESS_DEPTH = pfs_pkg::SUPPRESS_DEPTH_C
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pfs_pkg::item_t   item,
	output logic             result_strobe,
	output pfs_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata
);
	import pfs_pkg::*;

	cmd_t         cmd;
	ctrl_status_t stat;

	pfs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.result_strobe (result_strobe),
		.stat          (stat),
		.cmd           (cmd)
	);

	pfs_datapath #(.QDEPTH(QUEUE_DEPTH), .SDEPTH(SUPPRESS_DEPTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.result    (result)
	);
endmodule
